// ===== rtl/core/pgs_pkg.sv =====
// Package for the pigeonhole sorter: fixed field widths and sequencer states.
// No dependencies; imported by pigeonhole_sort.
package pgs_pkg;

	// Width of a key on either side
	localparam int KEY_W  = 7;
	// Stream data width, key padded to a whole byte
	localparam int DATA_W = 8;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_READ,
		ST_EMIT,
		ST_CLEAR
	} pgs_state_t;

endpackage

// ===== rtl/core/pgs_bin_ram.sv =====
// Bin count store: one write port, one registered read port, per-entry valid bits.
// Self-contained, no package needed; instantiated by pigeonhole_sort.
module pgs_bin_ram #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7,
	parameter int CNT_W  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [CNT_W-1:0]  wr_data,
	input  logic              clr_all,
	output logic [CNT_W-1:0]  rd_data
);
	logic [CNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] rd_word_q;
	logic             rd_vld_q;

	// Write the count array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read the count array, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Track written entries; clear all at reset and at end of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
			if (clr_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Unwritten entries read as zero
	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

// ===== rtl/core/pigeonhole_sort.sv =====
// Pigeonhole (counting) sorter top level: load sequencer, bin walk and output register.
// Depends on pgs_pkg and pgs_bin_ram.
//
// Channel | Dir | Word contents                          | Accepted when
// s_*     | in  | tdata[6:0] key_value, tlast last_item  | s_tvalid && s_tready
// m_*     | out | tdata[6:0] sorted_key, tlast last_result, tuser overflowed
//                                                        | m_tvalid && m_tready
//
// Loading takes one key per cycle; a key's bin is read as the key is taken and written
// the cycle after, with a bypass when consecutive keys hit the same bin.
// After the last key the bin store is walked from key 0 upward: each bin visited is read,
// then its results are emitted; the walk ends at the bin holding the final result, and
// the bin store is then cleared. s_tready stays low for the whole walk.
// Reset clears all bins through per-entry valid bits; no clearing pass is needed.
// m_tready low holds the output register and pauses the walk.
module pigeonhole_sort #(
	parameter int KEY_RANGE = 128,
	parameter int MAX_ITEMS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [pgs_pkg::DATA_W-1:0] s_tdata,  // [6:0] key_value, [7] zero
	input  logic                      s_tlast,  // last_item
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pgs_pkg::DATA_W-1:0] m_tdata,  // [6:0] sorted_key, [7] zero
	output logic                      m_tlast,  // last_result
	output logic                      m_tuser   // [0] overflowed
);
	import pgs_pkg::*;

	localparam int BIN_W = (KEY_RANGE > 1) ? $clog2(KEY_RANGE) : 1;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	pgs_state_t state_q, state_d;

	logic [KEY_W-1:0] in_key;
	logic [BIN_W-1:0] in_bin;
	logic             in_acc;
	logic             in_count;

	logic [CNT_W-1:0] items_q;
	logic             ovf_q;

	logic             upd_vld_s1;
	logic [BIN_W-1:0] bin_s1;
	logic             fwd_s1;
	logic [CNT_W-1:0] fwd_val_s1;
	logic [CNT_W-1:0] new_cnt;

	logic [BIN_W-1:0] bin_q;
	logic [CNT_W-1:0] emit_cnt_q;
	logic [CNT_W-1:0] left_q;
	logic             bin_done;
	logic             bin_last;
	logic             slot_free;
	logic             emit_go;

	logic             rd_en;
	logic [BIN_W-1:0] rd_addr;
	logic             clr_all;
	logic [CNT_W-1:0] rd_data;

	logic             out_vld_q;
	logic [KEY_W-1:0] out_key_q;
	logic             out_last_q;
	logic             out_ovf_q;

	// Decode the input word
	assign in_key   = s_tdata[KEY_W-1:0];
	assign in_bin   = BIN_W'(in_key);
	assign in_acc   = s_tvalid && s_tready;
	assign in_count = (32'(in_key) < KEY_RANGE) && (32'(items_q) < MAX_ITEMS);

	// Bin count with bypass of the write still in flight
	assign new_cnt = (fwd_s1 ? fwd_val_s1 : rd_data) + CNT_W'(1);

	// Walk status
	assign bin_done  = (emit_cnt_q == rd_data);
	assign bin_last  = (32'(bin_q) == KEY_RANGE - 1);
	assign slot_free = !out_vld_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && s_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = (items_q == '0) ? ST_CLEAR : ST_READ;
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (bin_done) begin
					state_d = bin_last ? ST_CLEAR : ST_READ;
				end else if (slot_free && left_q == CNT_W'(1)) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = bin_q;
		clr_all  = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				rd_en    = in_acc && in_count;
				rd_addr  = in_bin;
			end
			ST_DRAIN: begin
			end
			ST_READ: begin
				rd_en = 1'b1;
			end
			ST_EMIT: begin
				emit_go = !bin_done && slot_free;
			end
			ST_CLEAR: begin
				clr_all = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Load side: count keys, flag drops, stage the bin update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q    <= '0;
			ovf_q      <= 1'b0;
			upd_vld_s1 <= 1'b0;
		end else begin
			upd_vld_s1 <= in_acc && in_count;
			if (clr_all) begin
				items_q <= '0;
				ovf_q   <= 1'b0;
			end else if (in_acc) begin
				if (in_count) begin
					items_q <= items_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Hold the bin address and bypass data for the update stage
	always_ff @(posedge clk) begin
		if (in_acc && in_count) begin
			bin_s1     <= in_bin;
			fwd_s1     <= upd_vld_s1 && (bin_s1 == in_bin);
			fwd_val_s1 <= new_cnt;
		end
	end

	// Walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q      <= '0;
			emit_cnt_q <= '0;
			left_q     <= '0;
		end else begin
			if (state_q == ST_DRAIN) begin
				left_q <= items_q;
			end else if (emit_go) begin
				left_q <= left_q - CNT_W'(1);
			end
			if (clr_all) begin
				bin_q      <= '0;
				emit_cnt_q <= '0;
			end else if (state_q == ST_EMIT) begin
				if (bin_done) begin
					emit_cnt_q <= '0;
					if (!bin_last) begin
						bin_q <= bin_q + BIN_W'(1);
					end
				end else if (emit_go) begin
					emit_cnt_q <= emit_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Bin store
	pgs_bin_ram #(
		.DEPTH  (KEY_RANGE),
		.ADDR_W (BIN_W),
		.CNT_W  (CNT_W)
	) u_bins (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (upd_vld_s1),
		.wr_addr (bin_s1),
		.wr_data (new_cnt),
		.clr_all (clr_all),
		.rd_data (rd_data)
	);

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_key_q  <= KEY_W'(bin_q);
			out_last_q <= (left_q == CNT_W'(1));
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = DATA_W'(out_key_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule
